// ===== hdl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Codes, state encoding and memory request type of the CPU subset execute
// unit.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  localparam logic [2:0] OP_LDA = 3'd0;
  localparam logic [2:0] OP_STA = 3'd1;
  localparam logic [2:0] OP_TAX = 3'd2;
  localparam logic [2:0] OP_ADC = 3'd3;
  localparam logic [2:0] OP_INX = 3'd4;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ZPY  = 4'd3;
  localparam logic [3:0] MODE_ABS  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_INDX = 4'd7;
  localparam logic [3:0] MODE_INDY = 4'd8;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ADDR    = 7'b0000010,
    S_PTR_HI  = 7'b0000100,
    S_PTR_END = 7'b0001000,
    S_EXEC    = 7'b0010000,
    S_RDATA   = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

endpackage

// ===== hdl/cse_mem.sv =====
// ----------------------------------------------------------------------------
// cse_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module cse_mem
  import cse_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata_r
);

  localparam int Depth = 1 << MEM_ADDR_BITS;

  logic [7:0] mem_r [Depth];
  logic [MEM_ADDR_BITS-1:0] addr;

  assign addr = req.addr[MEM_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_r[addr];
    end
  end

endmodule

// ===== hdl/cpu_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_subset_execute_unit
// Executes one decoded instruction of an 8-bit CPU subset, or one memory
// byte write or read, per input transfer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  cmd, op, mode, operand, mem_addr,
//                                          mem_data
//   out_     output     out_valid/out_stall acc, index_x, flags, read_data,
//                                          eff_addr
//   cfg_     input      cfg_valid/cfg_ready index_y
//
// From one input transfer to the next, a memory write, an implied
// instruction, an item that does nothing or a store in immediate or direct
// modes passes S_ADDR and S_FINISH; a read adds S_RDATA, a load or add with
// an immediate or direct operand adds S_EXEC, and the indirect modes add
// S_PTR_HI and S_PTR_END, whose two pointer reads and data read go in turn
// through the single memory port and one shared adder.
// Reset clears the sequencer, acc, X, flags, Y and out_valid, not memory.
// The result waits in an output register, so a stalled output holds only
// the next finished item, not the next input transfer.
// ----------------------------------------------------------------------------
module cpu_subset_execute_unit
  import cse_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_operand,
  input  logic [15:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_acc,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_flags,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_eff_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index_y
);

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [15:0] opnd_r, opnd_nxt;
  logic [15:0] maddr_r, maddr_nxt;
  logic [7:0]  mdata_r, mdata_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  x_r, x_nxt;
  logic        c_r, c_nxt;
  logic        z_r, z_nxt;
  logic        n_r, n_nxt;
  logic [15:0] ea_r, ea_nxt;
  logic [15:0] ea_out_r, ea_out_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic [7:0]  idx_y_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_acc_r, out_x_r, out_flags_r, out_rd_r;
  logic [15:0] out_ea_r;
  logic        out_load;

  logic [15:0] add_a, add_b;
  logic        add_ci;
  logic [16:0] add_sum;
  logic        go_mem;
  logic [15:0] eff;
  logic [7:0]  val;
  logic        in_accept;

  mem_req_t    mem_req;
  logic [7:0]  mem_rdata;

  cse_mem #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + {16'b0, add_ci};
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    op_nxt     = op_r;
    mode_nxt   = mode_r;
    opnd_nxt   = opnd_r;
    maddr_nxt  = maddr_r;
    mdata_nxt  = mdata_r;
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    c_nxt      = c_r;
    z_nxt      = z_r;
    n_nxt      = n_r;
    ea_nxt     = ea_r;
    ea_out_nxt = ea_out_r;
    rd_nxt     = rd_r;
    add_a      = 16'd0;
    add_b      = 16'd0;
    add_ci     = 1'b0;
    go_mem     = 1'b0;
    eff        = 16'd0;
    val        = 8'd0;
    mem_req    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_cmd;
          op_nxt     = in_op;
          mode_nxt   = in_mode;
          opnd_nxt   = in_operand;
          maddr_nxt  = in_mem_addr;
          mdata_nxt  = in_mem_data;
          rd_nxt     = 8'd0;
          ea_out_nxt = 16'd0;
          state_nxt  = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_FINISH;
        case (cmd_r)
          CMD_WRITE: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = maddr_r;
            mem_req.wdata = mdata_r;
          end
          CMD_READ: begin
            mem_req.re   = 1'b1;
            mem_req.addr = maddr_r;
            state_nxt    = S_RDATA;
          end
          CMD_EXEC: begin
            case (op_r)
              OP_TAX: begin
                x_nxt = acc_r;
                z_nxt = (acc_r == 8'd0);
                n_nxt = acc_r[7];
              end
              OP_INX: begin
                add_a = {8'd0, x_r};
                add_b = 16'd1;
                x_nxt = add_sum[7:0];
                z_nxt = (add_sum[7:0] == 8'd0);
                n_nxt = add_sum[7];
              end
              OP_LDA, OP_STA, OP_ADC: begin
                case (mode_r)
                  MODE_IMM: begin
                    if (op_r != OP_STA) begin
                      state_nxt = S_EXEC;
                    end
                  end
                  MODE_ZP: begin
                    go_mem = 1'b1;
                    eff    = {8'd0, opnd_r[7:0]};
                  end
                  MODE_ZPX: begin
                    add_a  = {8'd0, opnd_r[7:0]};
                    add_b  = {8'd0, x_r};
                    go_mem = 1'b1;
                    eff    = {8'd0, add_sum[7:0]};
                  end
                  MODE_ZPY: begin
                    add_a  = {8'd0, opnd_r[7:0]};
                    add_b  = {8'd0, idx_y_r};
                    go_mem = 1'b1;
                    eff    = {8'd0, add_sum[7:0]};
                  end
                  MODE_ABS: begin
                    go_mem = 1'b1;
                    eff    = opnd_r;
                  end
                  MODE_ABSX: begin
                    add_a  = opnd_r;
                    add_b  = {8'd0, x_r};
                    go_mem = 1'b1;
                    eff    = add_sum[15:0];
                  end
                  MODE_ABSY: begin
                    add_a  = opnd_r;
                    add_b  = {8'd0, idx_y_r};
                    go_mem = 1'b1;
                    eff    = add_sum[15:0];
                  end
                  MODE_INDX: begin
                    add_a        = {8'd0, opnd_r[7:0]};
                    add_b        = {8'd0, x_r};
                    ea_nxt       = {8'd0, add_sum[7:0]};
                    mem_req.re   = 1'b1;
                    mem_req.addr = {8'd0, add_sum[7:0]};
                    state_nxt    = S_PTR_HI;
                  end
                  MODE_INDY: begin
                    ea_nxt       = {8'd0, opnd_r[7:0]};
                    mem_req.re   = 1'b1;
                    mem_req.addr = {8'd0, opnd_r[7:0]};
                    state_nxt    = S_PTR_HI;
                  end
                  default: begin
                    state_nxt = S_FINISH;
                  end
                endcase
              end
              default: begin
                state_nxt = S_FINISH;
              end
            endcase
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_PTR_HI: begin
        add_a        = {8'd0, ea_r[7:0]};
        add_b        = 16'd1;
        mem_req.re   = 1'b1;
        mem_req.addr = {8'd0, add_sum[7:0]};
        ea_nxt       = {8'd0, mem_rdata};
        state_nxt    = S_PTR_END;
      end
      S_PTR_END: begin
        go_mem = 1'b1;
        if (mode_r == MODE_INDY) begin
          add_a = {mem_rdata, ea_r[7:0]};
          add_b = {8'd0, idx_y_r};
          eff   = add_sum[15:0];
        end else begin
          eff = {mem_rdata, ea_r[7:0]};
        end
      end
      S_EXEC: begin
        val       = (mode_r == MODE_IMM) ? opnd_r[7:0] : mem_rdata;
        state_nxt = S_FINISH;
        case (op_r)
          OP_LDA: begin
            acc_nxt = val;
            z_nxt   = (val == 8'd0);
            n_nxt   = val[7];
          end
          OP_ADC: begin
            add_a   = {8'd0, acc_r};
            add_b   = {8'd0, val};
            add_ci  = c_r;
            acc_nxt = add_sum[7:0];
            c_nxt   = add_sum[8];
            z_nxt   = (add_sum[7:0] == 8'd0);
            n_nxt   = add_sum[7];
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_RDATA: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_mem) begin
      ea_out_nxt   = eff;
      mem_req.addr = eff;
      if (op_r == OP_STA) begin
        mem_req.we    = 1'b1;
        mem_req.wdata = acc_r;
        state_nxt     = S_FINISH;
      end else begin
        mem_req.re = 1'b1;
        state_nxt  = S_EXEC;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= 8'd0;
      x_r         <= 8'd0;
      c_r         <= 1'b0;
      z_r         <= 1'b0;
      n_r         <= 1'b0;
      idx_y_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      x_r         <= x_nxt;
      c_r         <= c_nxt;
      z_r         <= z_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        idx_y_r <= cfg_index_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    op_r     <= op_nxt;
    mode_r   <= mode_nxt;
    opnd_r   <= opnd_nxt;
    maddr_r  <= maddr_nxt;
    mdata_r  <= mdata_nxt;
    ea_r     <= ea_nxt;
    ea_out_r <= ea_out_nxt;
    rd_r     <= rd_nxt;
    if (out_load) begin
      out_acc_r   <= acc_r;
      out_x_r     <= x_r;
      out_flags_r <= {n_r, 5'd0, z_r, c_r};
      out_rd_r    <= rd_r;
      out_ea_r    <= ea_out_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_acc       = out_acc_r;
  assign out_index_x   = out_x_r;
  assign out_flags     = out_flags_r;
  assign out_read_data = out_rd_r;
  assign out_eff_addr  = out_ea_r;

endmodule
